// ===== rtl/msc_pkg.sv =====
// Package for the coastline extractor: sizes, register indexes, cell table.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_W   = 11;
	localparam int COORD_W = 11;
	localparam int SEGN_W  = 21;

	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		EDGE_T = 2'd0,
		EDGE_R = 2'd1,
		EDGE_B = 2'd2,
		EDGE_L = 2'd3
	} edge_t;

	typedef struct packed {
		logic [1:0] n;
		edge_t      e0;
		edge_t      e1;
		edge_t      e2;
		edge_t      e3;
	} seg_entry_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// corners: bit0 top-left, bit1 top-right, bit2 bottom-right, bit3 bottom-left
	function automatic seg_entry_t seg_lookup(input logic [3:0] code);
		seg_entry_t s;
		s = '{n: 2'd0, e0: EDGE_T, e1: EDGE_T, e2: EDGE_T, e3: EDGE_T};
		case (code)
			4'd1:    s = '{2'd1, EDGE_L, EDGE_T, EDGE_T, EDGE_T};
			4'd2:    s = '{2'd1, EDGE_T, EDGE_R, EDGE_T, EDGE_T};
			4'd3:    s = '{2'd1, EDGE_L, EDGE_R, EDGE_T, EDGE_T};
			4'd4:    s = '{2'd1, EDGE_R, EDGE_B, EDGE_T, EDGE_T};
			4'd5:    s = '{2'd2, EDGE_L, EDGE_T, EDGE_R, EDGE_B};
			4'd6:    s = '{2'd1, EDGE_T, EDGE_B, EDGE_T, EDGE_T};
			4'd7:    s = '{2'd1, EDGE_L, EDGE_B, EDGE_T, EDGE_T};
			4'd8:    s = '{2'd1, EDGE_L, EDGE_B, EDGE_T, EDGE_T};
			4'd9:    s = '{2'd1, EDGE_T, EDGE_B, EDGE_T, EDGE_T};
			4'd10:   s = '{2'd2, EDGE_T, EDGE_R, EDGE_B, EDGE_L};
			4'd11:   s = '{2'd1, EDGE_R, EDGE_B, EDGE_T, EDGE_T};
			4'd12:   s = '{2'd1, EDGE_L, EDGE_R, EDGE_T, EDGE_T};
			4'd13:   s = '{2'd1, EDGE_T, EDGE_R, EDGE_T, EDGE_T};
			4'd14:   s = '{2'd1, EDGE_L, EDGE_T, EDGE_T, EDGE_T};
			default: s = '{n: 2'd0, e0: EDGE_T, e1: EDGE_T, e2: EDGE_T, e3: EDGE_T};
		endcase
		return s;
	endfunction

	// cx2, ry2: twice the current tile's column and row, already 11 bits
	function automatic point_t edge_point(input edge_t e, input logic [COORD_W-1:0] cx2,
			input logic [COORD_W-1:0] ry2);
		point_t p;
		p.x = cx2;
		p.y = ry2;
		case (e)
			EDGE_T: p.y = ry2 - COORD_W'(1);
			EDGE_R: p.x = cx2 + COORD_W'(1);
			EDGE_B: p.y = ry2 + COORD_W'(1);
			EDGE_L: p.x = cx2 - COORD_W'(1);
			default: p.x = cx2;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/marching_squares_coastline.sv =====
// Marching-squares coastline extractor: line buffer, cell stage, segment output.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  in       | input     | in_valid / in_stall   | land
//  out      | output    | out_valid / out_stall | start_x start_y end_x end_y
//           |           |                       | segment_number last_of_cell map_done
//  cfg      | input     | cfg_we                | cfg_index cfg_wdata
//
// One tile per cycle when the output does not stall and its cell gives at most one segment;
// a saddle cell holds the cell stage until both its segments have gone to the single segment
// output register. A tile's first segment passes the line-buffer read, cell decode and
// output registers. Reset clears control state only; line-buffer data read in a map's
// first row is ignored. A stall on the output backs up through the cell stage to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module marching_squares_coastline
	import msc_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                land,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [COORD_W-1:0]       start_x,
	output logic [COORD_W-1:0]       start_y,
	output logic [COORD_W-1:0]       end_x,
	output logic [COORD_W-1:0]       end_y,
	output logic [SEGN_W-1:0]        segment_number,
	output logic                     last_of_cell,
	output logic                     map_done,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_wdata
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);

	// configuration
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [31:0]   cfg_val;
	logic          cfg_w_sel;
	logic          cfg_h_sel;

	// tile counters and neighbor state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          left_q;
	logic          upleft_q;
	logic [SEGN_W-1:0] segcnt_q;
	logic          col_last;
	logic          row_last;

	// line buffer
	logic          lb_mem [MAX_WIDTH];

	// stage 1: tile with line-buffer read data
	logic          valid_s1;
	logic          land_s1;
	logic          above_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          last_col_s1;
	logic          done_s1;

	// stage 2: decoded cell
	logic          valid_s2;
	seg_entry_t    seg_s2;
	logic [CW-1:0] col_s2;
	logic [RW-1:0] row_s2;
	logic          done_s2;
	logic          phase_s2;

	// output register
	logic          out_valid_q;

	logic          in_acc;
	logic          out_free;
	logic          s2_final;
	logic          s2_free;
	logic          s1_move;
	logic          above_eff;
	logic [3:0]    code_s1;
	seg_entry_t    seg_s1;
	edge_t         e_from;
	edge_t         e_to;
	logic [COORD_W-1:0] cx2;
	logic [COORD_W-1:0] ry2;
	point_t        p_from;
	point_t        p_to;
	logic          emit;

	assign cfg_val   = 32'(cfg_wdata);
	assign cfg_w_sel = cfg_we && (cfg_index == REG_MAP_WIDTH);
	assign cfg_h_sel = cfg_we && (cfg_index == REG_MAP_HEIGHT);

	assign col_last = (WW'(col_q) + WW'(1)) >= width_q;
	assign row_last = (HW'(row_q) + HW'(1)) >= height_q;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_final = !seg_s2.n[1] || phase_s2;
	assign emit     = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || (out_free && s2_final);
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	assign above_eff = (row_s1 != '0) ? above_s1 : 1'b0;
	assign code_s1   = {left_q, land_s1, above_eff, upleft_q};
	assign seg_s1    = seg_lookup(code_s1);

	assign e_from = phase_s2 ? seg_s2.e2 : seg_s2.e0;
	assign e_to   = phase_s2 ? seg_s2.e3 : seg_s2.e1;
	assign cx2    = COORD_W'({col_s2, 1'b0});
	assign ry2    = COORD_W'({row_s2, 1'b0});
	assign p_from = edge_point(e_from, cx2, ry2);
	assign p_to   = edge_point(e_to, cx2, ry2);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(2);
			height_q <= HW'(2);
		end else begin
			if (cfg_w_sel) begin
				if (cfg_val < 32'd2)
					width_q <= WW'(2);
				else if (cfg_val > 32'(MAX_WIDTH))
					width_q <= WW'(MAX_WIDTH);
				else
					width_q <= WW'(cfg_val);
			end
			if (cfg_h_sel) begin
				if (cfg_val < 32'd2)
					height_q <= HW'(2);
				else if (cfg_val > 32'(MAX_HEIGHT))
					height_q <= HW'(MAX_HEIGHT);
				else
					height_q <= HW'(cfg_val);
			end
		end
	end

	// tile counters advance on accept and clear on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read-before-write: the old entry is the tile above
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1      <= lb_mem[col_q];
			lb_mem[col_q] <= land;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			land_s1     <= land;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= col_last;
			done_s1     <= col_last && row_last;
		end
	end

	// neighbor tiles follow the cell stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 1'b0;
			upleft_q <= 1'b0;
		end else if (cfg_we) begin
			left_q   <= 1'b0;
			upleft_q <= 1'b0;
		end else if (s1_move) begin
			left_q   <= last_col_s1 ? 1'b0 : land_s1;
			upleft_q <= last_col_s1 ? 1'b0 : above_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && (col_s1 != '0) && (row_s1 != '0) && (seg_s1.n != 2'd0);
			phase_s2 <= 1'b0;
		end else if (emit) begin
			phase_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			seg_s2  <= seg_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			done_s2 <= done_s1;
		end
	end

	// a tile that ends the map restarts numbering after its own segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segcnt_q <= '0;
		end else if (cfg_we) begin
			segcnt_q <= '0;
		end else if (s1_move && done_s1 && ((col_s1 == '0) || (row_s1 == '0) ||
				(seg_s1.n == 2'd0))) begin
			segcnt_q <= '0;
		end else if (emit) begin
			segcnt_q <= (s2_final && done_s2) ? '0 : segcnt_q + SEGN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			start_x        <= p_from.x;
			start_y        <= p_from.y;
			end_x          <= p_to.x;
			end_y          <= p_to.y;
			segment_number <= segcnt_q;
			last_of_cell   <= s2_final;
			map_done       <= done_s2;
		end
	end

endmodule

`default_nettype wire

// ===== tb/marching_squares_coastline_tb.sv =====
// Self-checking testbench for the marching-squares coastline extractor.
`timescale 1ns / 1ps

module marching_squares_coastline_tb;
	import msc_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int MAX_H         = MAX_HEIGHT_DEF;
	localparam int DRAIN_CYCLES  = 12;
	localparam int RANDOM_TILES  = 1750;
	localparam int QUIET_TILES   = 300;

	typedef struct packed {
		logic [1:0] count;
		edge_t      from0;
		edge_t      to0;
		edge_t      from1;
		edge_t      to1;
	} crossing_t;

	typedef struct packed {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [SEGN_W-1:0]  num;
		logic               last;
		logic               done;
	} coastline_seg_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic               land      = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [SEGN_W-1:0]  segment_number;
	logic               last_of_cell;
	logic               map_done;
	logic               cfg_we    = 1'b0;
	reg_index_t         cfg_index = REG_MAP_WIDTH;
	logic [CFG_W-1:0]   cfg_wdata = '0;

	// predictor state
	bit                 row_above [MAX_W];
	bit                 left_prev;
	bit                 upleft_prev;
	int unsigned        col_pos;
	int unsigned        row_pos;
	logic [SEGN_W-1:0]  seg_count;
	int unsigned        map_w;
	int unsigned        map_h;

	bit                 tile_q [$];
	coastline_seg_t     expected_segs [$];
	bit                 tile_taken;
	int unsigned        in_gap;
	int unsigned        out_hold;
	int unsigned        idle_pct;
	int unsigned        error_count;

	marching_squares_coastline i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.land           (land),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.start_x        (start_x),
		.start_y        (start_y),
		.end_x          (end_x),
		.end_y          (end_y),
		.segment_number (segment_number),
		.last_of_cell   (last_of_cell),
		.map_done       (map_done),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned clamp_dim(input int unsigned val, input int unsigned hi);
		int unsigned v;
		v = val & 32'h7FF;
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	// a code and its complement cross the same edges, saddles aside
	function automatic crossing_t cell_crossings(input logic [3:0] code);
		crossing_t x;
		logic [3:0] base;
		x = '{count: 2'd1, from0: EDGE_T, to0: EDGE_T, from1: EDGE_T, to1: EDGE_T};
		base = code[3] ? ~code : code;
		case (base)
			4'd1: begin
				x.from0 = EDGE_L; x.to0 = EDGE_T;
			end
			4'd2: begin
				x.from0 = EDGE_T; x.to0 = EDGE_R;
			end
			4'd3: begin
				x.from0 = EDGE_L; x.to0 = EDGE_R;
			end
			4'd4: begin
				x.from0 = EDGE_R; x.to0 = EDGE_B;
			end
			4'd5: begin
				x.count = 2'd2;
				if (code[3]) begin
					x.from0 = EDGE_T; x.to0 = EDGE_R; x.from1 = EDGE_B; x.to1 = EDGE_L;
				end else begin
					x.from0 = EDGE_L; x.to0 = EDGE_T; x.from1 = EDGE_R; x.to1 = EDGE_B;
				end
			end
			4'd6: begin
				x.from0 = EDGE_T; x.to0 = EDGE_B;
			end
			4'd7: begin
				x.from0 = EDGE_L; x.to0 = EDGE_B;
			end
			default: x.count = 2'd0;
		endcase
		return x;
	endfunction

	// c, r: current tile (bottom-right corner of the cell)
	function automatic point_t edge_midpoint(input edge_t e, input int unsigned c,
			input int unsigned r);
		point_t p;
		p.x = COORD_W'(2 * c);
		p.y = COORD_W'(2 * r);
		case (e)
			EDGE_T: p.y = COORD_W'(2 * r - 1);
			EDGE_R: p.x = COORD_W'(2 * c + 1);
			EDGE_B: p.y = COORD_W'(2 * r + 1);
			default: p.x = COORD_W'(2 * c - 1);
		endcase
		return p;
	endfunction

	task automatic restart_map();
		left_prev   = 1'b0;
		upleft_prev = 1'b0;
		col_pos     = 0;
		row_pos     = 0;
		seg_count   = '0;
	endtask

	task automatic apply_size(input reg_index_t idx, input logic [CFG_W-1:0] val);
		if (idx == REG_MAP_WIDTH)
			map_w = clamp_dim(val, MAX_W);
		else
			map_h = clamp_dim(val, MAX_H);
		restart_map();
	endtask

	task automatic predict_tile(input bit tile);
		int unsigned    c;
		int unsigned    r;
		bit             above;
		bit             done;
		crossing_t      cr;
		coastline_seg_t s;
		point_t         pa;
		point_t         pb;
		c = col_pos;
		r = row_pos;
		above = (r != 0) ? row_above[c] : 1'b0;
		done = (c + 1 >= map_w) && (r + 1 >= map_h);
		if (c != 0 && r != 0) begin
			cr = cell_crossings({left_prev, tile, above, upleft_prev});
			for (int k = 0; k < int'(cr.count); k++) begin
				pa = edge_midpoint(k == 0 ? cr.from0 : cr.from1, c, r);
				pb = edge_midpoint(k == 0 ? cr.to0 : cr.to1, c, r);
				s.sx   = pa.x;
				s.sy   = pa.y;
				s.ex   = pb.x;
				s.ey   = pb.y;
				s.num  = seg_count;
				s.last = (k == int'(cr.count) - 1);
				s.done = done;
				expected_segs.push_back(s);
				seg_count = seg_count + 1'b1;
			end
		end
		row_above[c] = tile;
		left_prev    = tile;
		upleft_prev  = above;
		if (c + 1 >= map_w) begin
			col_pos     = 0;
			left_prev   = 1'b0;
			upleft_prev = 1'b0;
			if (r + 1 >= map_h) begin
				row_pos   = 0;
				seg_count = '0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			error_count++;
		end
	endtask

	// prediction on accepted tiles and register writes, checking of segments
	always @(posedge clk) begin
		coastline_seg_t e;
		if (arst_n) begin
			if (cfg_we)
				apply_size(cfg_index, cfg_wdata);
			if (in_valid && !in_stall) begin
				predict_tile(land);
				tile_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (expected_segs.size() == 0) begin
					$error("segment: expected none, actual segment_number %0d", segment_number);
					error_count++;
				end else begin
					e = expected_segs.pop_front();
					check_field("start_x", e.sx, start_x);
					check_field("start_y", e.sy, start_y);
					check_field("end_x", e.ex, end_x);
					check_field("end_y", e.ey, end_y);
					check_field("segment_number", e.num, segment_number);
					check_field("last_of_cell", e.last, last_of_cell);
					check_field("map_done", e.done, map_done);
				end
			end
		end
	end

	// tile driver
	always @(negedge clk) begin
		if (in_valid && !tile_taken) begin
			// hold the pending transaction
		end else if (in_gap > 0) begin
			in_gap--;
			in_valid <= 1'b0;
		end else if (tile_q.size() > 0) begin
			land     <= tile_q.pop_front();
			in_valid <= 1'b1;
			if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
				in_gap = $urandom_range(1, 7);
		end else begin
			in_valid <= 1'b0;
		end
		tile_taken = 1'b0;
	end

	// output back-pressure
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_hold--;
			out_stall <= 1'b1;
		end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			out_hold = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_tiles(input int unsigned n, input int unsigned pct);
		for (int unsigned i = 0; i < n; i++)
			tile_q.push_back($urandom_range(1, 100) <= pct);
	endtask

	// wait until every tile is in and every segment out, then let the pipe drain
	task automatic settle();
		while (tile_q.size() != 0 || in_valid || expected_segs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_size(input int unsigned w, input int unsigned h,
			input bit width_only);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAP_WIDTH;
		cfg_wdata <= CFG_W'(w);
		@(negedge clk);
		if (!width_only) begin
			cfg_index <= REG_MAP_HEIGHT;
			cfg_wdata <= CFG_W'(h);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [0:16]  top_row;
		logic [0:16]  bottom_row;
		int unsigned  random_tiles;
		int unsigned  n;
		int unsigned  w_val;
		int unsigned  h_val;
		int unsigned  cells;
		int unsigned  pct;
		bit           width_only;

		// column pairs of this sequence give all 16 cell codes
		top_row    = 17'b00100011101100110;
		bottom_row = 17'b00001010010111110;
		map_w = 2;
		map_h = 2;
		restart_map();
		idle_pct = 20;
		error_count = 0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset size 2x2: both saddles, then an all-water and an all-land map with no segment
		tile_q = '{1, 0, 0, 1, 0, 1, 1, 0, 0, 0, 0, 0, 1, 1, 1, 1};
		settle();

		program_size(17, 2, 1'b0);
		for (int i = 0; i < 17; i++)
			tile_q.push_back(top_row[i]);
		for (int i = 0; i < 17; i++)
			tile_q.push_back(bottom_row[i]);
		settle();

		// out-of-range sizes clamp to 2x2; a partial map is cut off by the next write
		program_size(0, 1, 1'b0);
		send_tiles(6, 50);
		settle();

		random_tiles = 0;
		while (random_tiles < RANDOM_TILES) begin
			if (random_tiles + QUIET_TILES >= RANDOM_TILES)
				idle_pct = 0;
			else
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			w_val = $urandom_range(2, 40);
			h_val = $urandom_range(2, 16);
			width_only = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 11))
				0: w_val = $urandom_range(0, 1);
				1: h_val = $urandom_range(0, 1);
				2: begin
					w_val = $urandom_range(100, 300);
					h_val = $urandom_range(2, 3);
					width_only = 1'b0;
				end
				3: h_val = $urandom_range(1025, 2047) & 11'h00F;
				default: ;
			endcase
			program_size(w_val, h_val, width_only);
			cells = map_w * map_h;
			case ($urandom_range(0, 4))
				0: pct = 10;
				1: pct = 30;
				2: pct = 50;
				3: pct = 70;
				default: pct = 90;
			endcase
			n = cells * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0)
				n += $urandom_range(1, cells - 1);
			// keep the total near the tile budget; a cut-off map is fine
			if (n > RANDOM_TILES - random_tiles)
				n = RANDOM_TILES - random_tiles;
			send_tiles(n, pct);
			random_tiles += n;
			settle();
		end

		settle();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/msc_pkg.sv
rtl/marching_squares_coastline.sv
tb/marching_squares_coastline_tb.sv
